/* design/hsl2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Widths, sextant codes, per-stage payload types and the channel clamp
// shared by the HSL to RGB converter and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hsl2rgb_pkg;

    localparam int FIELD_W  = 17;
    localparam int FRAC_W   = 16;
    localparam int DATA_W   = 56;
    localparam int NSTAGE   = 6;
    localparam int PROD1_W  = 35;
    localparam int V_W      = 21;
    localparam int MAG_W    = 20;
    localparam int PROD2_W  = MAG_W + FRAC_W;
    localparam int MID_W    = 22;

    localparam logic [FIELD_W-1:0] HALF_Q16 = 17'd32768;
    localparam logic [FIELD_W-1:0] ONE_Q16  = 17'd65536;

    typedef logic [FIELD_W-1:0]     t_field;
    typedef logic [FRAC_W-1:0]      t_frac;
    typedef logic [3:0]             t_sextant;
    typedef logic signed [V_W-1:0]  t_v;
    typedef logic signed [MID_W-1:0] t_mid;

    localparam t_sextant SEXT_RED_YEL = 4'd0;
    localparam t_sextant SEXT_YEL_GRN = 4'd1;
    localparam t_sextant SEXT_GRN_CYN = 4'd2;
    localparam t_sextant SEXT_CYN_BLU = 4'd3;
    localparam t_sextant SEXT_BLU_MAG = 4'd4;
    localparam t_sextant SEXT_MAG_RED = 4'd5;

    typedef struct packed {
        logic [PROD1_W-1:0] prod;
        logic               l_low;
        t_field             l;
        t_field             s;
        t_sextant           sext;
        t_frac              frac;
    } t_s1;

    typedef struct packed {
        t_v       v;
        t_field   l;
        t_sextant sext;
        t_frac    frac;
    } t_s2;

    typedef struct packed {
        t_v               v;
        t_v               m;
        t_field           l;
        logic             vpos;
        logic             dneg;
        logic [MAG_W-1:0] dmag;
        t_sextant         sext;
        t_frac            frac;
    } t_s3;

    typedef struct packed {
        t_v               v;
        t_v               m;
        t_field           l;
        logic             vpos;
        logic             dneg;
        logic [MAG_W-1:0] vsfmag;
        t_sextant         sext;
    } t_s4;

    typedef struct packed {
        t_v       v;
        t_v       m;
        t_mid     mid1;
        t_mid     mid2;
        t_field   l;
        logic     vpos;
        t_sextant sext;
    } t_s5;

    typedef struct packed {
        t_field b;
        t_field g;
        t_field r;
    } t_rgb;

    function automatic t_field sat_channel(input t_mid x);
        t_field res;
        if (x < 0) begin
            res = '0;
        end else if (x > $signed({{(MID_W-FIELD_W){1'b0}}, ONE_Q16})) begin
            res = ONE_Q16;
        end else begin
            res = x[FIELD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/hsl_to_rgb.sv */
// ----------------------------------------------------------------------------
// hsl_to_rgb
// Streaming HSL to RGB color converter, unsigned Q16 fixed point in and out.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock unless every stage is full and
// the output is stalled. The depth is set by the six register stages:
// one multiplier forming lightness times saturation, the v sum, the m and
// v - m terms, a second multiplier scaling v - m by the hue fraction, the
// two midpoints, and the channel select with clamping. Each full stage
// holds when the one after it is full and stalled, so bubbles close up and
// the input only stalls once every stage holds a pixel.
`default_nettype none

module hsl_to_rgb (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_s_tvalid,
    output logic                          o_s_tready,
    // Fields from bit 0: hue[16:0], saturation[33:17], lightness[50:34].
    input  wire  [hsl2rgb_pkg::DATA_W-1:0] i_s_tdata,
    output logic                          o_m_tvalid,
    input  wire                           i_m_tready,
    // Fields from bit 0: red_out[16:0], green_out[33:17], blue_out[50:34].
    output logic [hsl2rgb_pkg::DATA_W-1:0] o_m_tdata
);
    import hsl2rgb_pkg::*;

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] w_rdy;

    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    t_s4  r_s4, n_s4;
    t_s5  r_s5, n_s5;
    t_rgb r_out, n_out;

    t_field             w_h, w_s, w_l;
    logic [19:0]        w_h6;
    logic [17:0]        w_factor;
    t_v                 w_diff, w_d;
    logic [PROD2_W-1:0] w_prod2;
    t_mid               w_vsf, w_v, w_m, w_l6;

    always_comb begin
        w_rdy[NSTAGE-1] = !r_vld[NSTAGE-1] || i_m_tready;
        for (int k = NSTAGE-2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_s_tready = w_rdy[0];
    assign o_m_tvalid = r_vld[NSTAGE-1];
    assign o_m_tdata  = {{(DATA_W-3*FIELD_W){1'b0}}, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: hue times six and the lightness product.
    always_comb begin
        w_h  = i_s_tdata[FIELD_W-1:0];
        w_s  = i_s_tdata[2*FIELD_W-1:FIELD_W];
        w_l  = i_s_tdata[3*FIELD_W-1:2*FIELD_W];
        w_h6 = {1'b0, w_h, 2'b00} + {2'b00, w_h, 1'b0};
        n_s1.l_low = (w_l <= HALF_Q16);
        w_factor   = n_s1.l_low ? ({1'b0, w_s} + 18'd65536) : {1'b0, w_s};
        n_s1.prod  = {{(PROD1_W-FIELD_W){1'b0}}, w_l} * {{(PROD1_W-18){1'b0}}, w_factor};
        n_s1.l     = w_l;
        n_s1.s     = w_s;
        n_s1.sext  = w_h6[19:16];
        n_s1.frac  = w_h6[15:0];
    end

    // Stage 2: v.
    always_comb begin
        if (r_s1.l_low) begin
            n_s2.v = $signed({2'b00, r_s1.prod[PROD1_W-1:16]});
        end else begin
            n_s2.v = $signed({4'b0000, r_s1.l}) + $signed({4'b0000, r_s1.s})
                   - $signed({2'b00, r_s1.prod[PROD1_W-1:16]});
        end
        n_s2.l    = r_s1.l;
        n_s2.sext = r_s1.sext;
        n_s2.frac = r_s1.frac;
    end

    // Stage 3: m and the magnitude of v - m.
    always_comb begin
        w_diff    = r_s2.v - $signed({4'b0000, r_s2.l});
        w_d       = w_diff <<< 1;
        n_s3.v    = r_s2.v;
        n_s3.m    = $signed({3'b000, r_s2.l, 1'b0}) - r_s2.v;
        n_s3.l    = r_s2.l;
        n_s3.vpos = (r_s2.v > 0);
        n_s3.dneg = w_d[V_W-1];
        n_s3.dmag = w_d[V_W-1] ? MAG_W'(-w_d) : w_d[MAG_W-1:0];
        n_s3.sext = r_s2.sext;
        n_s3.frac = r_s2.frac;
    end

    // Stage 4: scale by the hue fraction.
    always_comb begin
        w_prod2     = {{FRAC_W{1'b0}}, r_s3.dmag} * {{MAG_W{1'b0}}, r_s3.frac};
        n_s4.v      = r_s3.v;
        n_s4.m      = r_s3.m;
        n_s4.l      = r_s3.l;
        n_s4.vpos   = r_s3.vpos;
        n_s4.dneg   = r_s3.dneg;
        n_s4.vsfmag = w_prod2[PROD2_W-1:FRAC_W];
        n_s4.sext   = r_s3.sext;
    end

    // Stage 5: rising and falling midpoints.
    always_comb begin
        w_vsf = $signed({2'b00, r_s4.vsfmag});
        if (r_s4.dneg) begin
            w_vsf = -w_vsf;
        end
        n_s5.v    = r_s4.v;
        n_s5.m    = r_s4.m;
        n_s5.mid1 = {r_s4.m[V_W-1], r_s4.m} + w_vsf;
        n_s5.mid2 = {r_s4.v[V_W-1], r_s4.v} - w_vsf;
        n_s5.l    = r_s4.l;
        n_s5.vpos = r_s4.vpos;
        n_s5.sext = r_s4.sext;
    end

    // Stage 6: channel select and clamp.
    always_comb begin
        w_v  = {r_s5.v[V_W-1], r_s5.v};
        w_m  = {r_s5.m[V_W-1], r_s5.m};
        w_l6 = $signed({{(MID_W-FIELD_W){1'b0}}, r_s5.l});
        n_out.r = sat_channel(w_l6);
        n_out.g = sat_channel(w_l6);
        n_out.b = sat_channel(w_l6);
        if (r_s5.vpos) begin
            case (r_s5.sext)
                SEXT_RED_YEL: begin
                    n_out.r = sat_channel(w_v);
                    n_out.g = sat_channel(r_s5.mid1);
                    n_out.b = sat_channel(w_m);
                end
                SEXT_YEL_GRN: begin
                    n_out.r = sat_channel(r_s5.mid2);
                    n_out.g = sat_channel(w_v);
                    n_out.b = sat_channel(w_m);
                end
                SEXT_GRN_CYN: begin
                    n_out.r = sat_channel(w_m);
                    n_out.g = sat_channel(w_v);
                    n_out.b = sat_channel(r_s5.mid1);
                end
                SEXT_CYN_BLU: begin
                    n_out.r = sat_channel(w_m);
                    n_out.g = sat_channel(r_s5.mid2);
                    n_out.b = sat_channel(w_v);
                end
                SEXT_BLU_MAG: begin
                    n_out.r = sat_channel(r_s5.mid1);
                    n_out.g = sat_channel(w_m);
                    n_out.b = sat_channel(w_v);
                end
                SEXT_MAG_RED: begin
                    n_out.r = sat_channel(w_v);
                    n_out.g = sat_channel(w_m);
                    n_out.b = sat_channel(r_s5.mid2);
                end
                default: begin
                    n_out.r = sat_channel(w_l6);
                    n_out.g = sat_channel(w_l6);
                    n_out.b = sat_channel(w_l6);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s1 <= n_s1;
        end
        if (w_rdy[1]) begin
            r_s2 <= n_s2;
        end
        if (w_rdy[2]) begin
            r_s3 <= n_s3;
        end
        if (w_rdy[3]) begin
            r_s4 <= n_s4;
        end
        if (w_rdy[4]) begin
            r_s5 <= n_s5;
        end
        if (w_rdy[5]) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

/* design/hsl2rgb_chk.sv */
// ----------------------------------------------------------------------------
// hsl2rgb_chk
// Port-level checks for the HSL to RGB converter, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl2rgb_chk (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            o_s_tready,
    input wire                            o_m_tvalid,
    input wire                            i_m_tready,
    input wire [hsl2rgb_pkg::DATA_W-1:0]  o_m_tdata
);
    import hsl2rgb_pkg::*;

    logic w_in_range;

    assign w_in_range = (o_m_tdata[FIELD_W-1:0] <= ONE_Q16)
                     && (o_m_tdata[2*FIELD_W-1:FIELD_W] <= ONE_Q16)
                     && (o_m_tdata[3*FIELD_W-1:2*FIELD_W] <= ONE_Q16)
                     && (o_m_tdata[DATA_W-1:3*FIELD_W] == '0);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output changed");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> w_in_range)
        else $error("channel out of range or padding set");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid || i_m_tready |-> o_s_tready)
        else $error("input stalled while output can move");

endmodule

bind hsl_to_rgb hsl2rgb_chk u_hsl2rgb_chk (.*);

`default_nettype wire
